// File: rtl/core/c2gb_pkg.sv
// shared constants, stage payload types and the month table for the calendar to week converter
package c2gb_pkg;

  localparam int unsigned DAYS_TO_EPOCH   = 723263;
  localparam int unsigned DAY_SECONDS     = 86400;
  localparam int unsigned SEC_PER_WEEK    = 604800;
  localparam int unsigned BDS_WEEK_OFFSET = 1356;
  localparam int unsigned BDS_SEC_OFFSET  = 14;
  // days are biased by whole weeks so the divide by seven never sees a negative count
  localparam int unsigned WEEK_BIAS       = 112;
  localparam int unsigned DAY_BIAS        = 7 * WEEK_BIAS;
  // reciprocal of 7 scaled by 2^23, exact for a 20 bit dividend
  localparam int unsigned RECIP7          = 1198373;
  localparam int unsigned RECIP7_SHIFT    = 23;
  // reciprocal of 4725 scaled by 2^33, exact for a 20 bit dividend (604800 = 128 * 4725)
  localparam int unsigned RECIP4725       = 1817976;
  localparam int unsigned RECIP4725_SHIFT = 33;

  // stage 1 result: signed day count since the epoch and time of day
  typedef struct packed {
    logic [20:0] days;
    logic [26:0] tod;
    logic [25:0] frac;
  } c2gb_date_t;

  // stage 3 result: week pieces ready for the final carry
  typedef struct packed {
    logic        neg;
    logic [2:0]  dow;
    logic [19:0] rem;
    logic [17:0] wsum;
    logic [25:0] frac;
  } c2gb_split_t;

  // floor(30.6001 * (m + 1)) with january and february moved to the previous year
  function automatic logic [8:0] month_days(input logic [3:0] month);
    logic [8:0] val;
    case (month)
      4'd0:    val = 9'd397;
      4'd1:    val = 9'd428;
      4'd2:    val = 9'd459;
      4'd3:    val = 9'd122;
      4'd4:    val = 9'd153;
      4'd5:    val = 9'd183;
      4'd6:    val = 9'd214;
      4'd7:    val = 9'd244;
      4'd8:    val = 9'd275;
      4'd9:    val = 9'd306;
      4'd10:   val = 9'd336;
      4'd11:   val = 9'd367;
      4'd12:   val = 9'd397;
      4'd13:   val = 9'd428;
      4'd14:   val = 9'd459;
      default: val = 9'd489;
    endcase
    return val;
  endfunction

endpackage

// File: rtl/core/c2gb_date.sv
// stage 1: day count from the julian date rule and time of day in whole seconds
module c2gb_date
  import c2gb_pkg::*;
#(
  parameter int FRAC_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] year,
  input  logic [3:0]  month,
  input  logic [4:0]  day,
  input  logic [4:0]  hour,
  input  logic [5:0]  minute,
  input  logic [25:0] second_fixed,
  output logic        dn_valid,
  input  logic        dn_stall,
  output c2gb_date_t  dn_data
);

  localparam logic [25:0] FRAC_MASK = 26'((64'd1 << FRAC_BITS) - 64'd1);

  logic              early;
  logic signed [12:0] yadj;
  logic signed [23:0] quad;
  logic signed [23:0] qday;
  c2gb_date_t        data_next;
  logic              move;

  always_comb begin
    early = (month <= 4'd2);
    yadj  = early ? $signed({1'b0, year}) - 13'sd1 : $signed({1'b0, year});
    quad  = $signed({{11{yadj[12]}}, yadj}) * 24'sd1461;
    // arithmetic shift floors toward minus infinity for year -1
    qday  = quad >>> 2;
    data_next.days = qday[20:0] + 21'(month_days(month)) + 21'(day) - 21'(DAYS_TO_EPOCH);
    data_next.tod  = 27'(hour) * 27'(3600) + 27'(minute) * 27'(60)
                   + 27'(second_fixed >> FRAC_BITS);
    data_next.frac = second_fixed & FRAC_MASK;
  end

  assign move     = !dn_valid || !dn_stall;
  assign in_stall = !move;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (move) begin
      dn_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      dn_data <= data_next;
    end
  end

endmodule

// File: rtl/core/c2gb_divide.sv
// stages 2 and 3: sign of the total, days split by seven and time of day split by week
module c2gb_divide
  import c2gb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  output logic        up_stall,
  input  c2gb_date_t  up_data,
  output logic        dn_valid,
  input  logic        dn_stall,
  output c2gb_split_t dn_data
);

  // stage 2 registers
  logic               v2;
  logic signed [37:0] prod_day;
  logic [26:0]        tod;
  logic [19:0]        xd;
  logic [17:0]        qd;
  logic [7:0]         w2;
  logic [25:0]        frac;

  logic               move2;
  logic               move3;
  logic [19:0]        xd_next;
  logic signed [37:0] prod_next;
  logic [40:0]        qd_prod;
  logic [40:0]        tw_prod;
  logic [37:0]        total;
  logic [19:0]        back7;
  logic [26:0]        back_week;
  c2gb_split_t        split_next;

  assign move3    = !dn_valid || !dn_stall;
  assign move2    = !v2 || move3;
  assign up_stall = !move2;

  always_comb begin
    xd_next   = 20'(up_data.days + 21'(DAY_BIAS));
    prod_next = $signed({{17{up_data.days[20]}}, up_data.days}) * $signed(38'(DAY_SECONDS));
    qd_prod   = 41'(xd_next) * 41'(RECIP7);
    tw_prod   = 41'(up_data.tod[26:7]) * 41'(RECIP4725);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (move2) begin
      v2 <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move2) begin
      prod_day <= prod_next;
      tod      <= up_data.tod;
      xd       <= xd_next;
      qd       <= qd_prod[RECIP7_SHIFT +: 18];
      w2       <= tw_prod[RECIP4725_SHIFT +: 8];
      frac     <= up_data.frac;
    end
  end

  always_comb begin
    total      = prod_day + $signed({11'd0, tod});
    back7      = 20'(qd) * 20'd7;
    back_week  = 27'(w2) * 27'(SEC_PER_WEEK);
    split_next.neg  = total[37];
    split_next.dow  = 3'(xd - back7);
    split_next.rem  = 20'(tod - back_week);
    split_next.wsum = qd + 18'(w2);
    split_next.frac = frac;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (move3) begin
      dn_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (move3) begin
      dn_data <= split_next;
    end
  end

endmodule

// File: rtl/core/c2gb_assemble.sv
// stages 4 and 5: seconds of week with week carry, beidou offsets and the result register
module c2gb_assemble
  import c2gb_pkg::*;
#(
  parameter int FRAC_BITS = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_stall,
  input  c2gb_split_t        up_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [16:0]        gps_week,
  output logic [39:0]        gps_seconds,
  output logic signed [17:0] bds_week,
  output logic [39:0]        bds_seconds,
  output logic               before_epoch
);

  // stage 4 registers
  logic        v4;
  logic        neg;
  logic [19:0] sec;
  logic [17:0] week;
  logic [25:0] frac;

  logic        move4;
  logic        move5;
  logic [20:0] sum;
  logic        carry;
  logic        borrow;
  logic [19:0] bsec;
  logic [17:0] bweek;
  logic [63:0] gwide;
  logic [63:0] bwide;

  assign move5    = !out_valid || !out_stall;
  assign move4    = !v4 || move5;
  assign up_stall = !move4;

  always_comb begin
    sum   = 21'(up_data.dow) * 21'(DAY_SECONDS) + 21'(up_data.rem);
    carry = (sum >= 21'(SEC_PER_WEEK));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (move4) begin
      v4 <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move4) begin
      neg  <= up_data.neg;
      sec  <= carry ? 20'(sum - 21'(SEC_PER_WEEK)) : sum[19:0];
      week <= up_data.wsum + 18'(carry) - 18'(WEEK_BIAS);
      frac <= up_data.frac;
    end
  end

  always_comb begin
    // borrow a week when the beidou second offset underflows
    borrow = (sec < 20'(BDS_SEC_OFFSET));
    bsec   = borrow ? sec + 20'(SEC_PER_WEEK - BDS_SEC_OFFSET) : sec - 20'(BDS_SEC_OFFSET);
    bweek  = week - 18'(BDS_WEEK_OFFSET) - 18'(borrow);
    gwide  = (64'(sec) << FRAC_BITS) | 64'(frac);
    bwide  = (64'(bsec) << FRAC_BITS) | 64'(frac);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move5) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (move5) begin
      before_epoch <= neg;
      gps_week     <= neg ? 17'd0 : week[16:0];
      gps_seconds  <= neg ? 40'd0 : gwide[39:0];
      bds_week     <= neg ? 18'sd0 : $signed(bweek);
      bds_seconds  <= neg ? 40'd0 : bwide[39:0];
    end
  end

endmodule

// File: rtl/core/calendar_to_gps_bds_week_second_top.sv
// Calendar date and time of day to GPS and BeiDou week and seconds of week.
// A five stage pipeline that takes one timestamp every clock cycle while the
// output is not stalled; a stall on the output holds the full stages back to
// the first empty one, and the input is stalled only when the pipe is full.
// The stages are the day count from the Julian date rule, constant
// multiplies by the reciprocals of 7 and 604800, the carry into the week, and
// the BeiDou offsets (1356 weeks, 14 s) in the result register. Seconds carry
// FRAC_BITS fraction bits; instants before 1980-01-06 give all zero fields
// with before_epoch set.
module calendar_to_gps_bds_week_second_top
  import c2gb_pkg::*;
#(
  parameter int FRAC_BITS = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        year,
  input  logic [3:0]         month,
  input  logic [4:0]         day,
  input  logic [4:0]         hour,
  input  logic [5:0]         minute,
  input  logic [25:0]        second_fixed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [16:0]        gps_week,
  output logic [39:0]        gps_seconds,
  output logic signed [17:0] bds_week,
  output logic [39:0]        bds_seconds,
  output logic               before_epoch
);

  logic        date_valid;
  logic        date_stall;
  c2gb_date_t  date_data;
  logic        split_valid;
  logic        split_stall;
  c2gb_split_t split_data;

  c2gb_date #(
    .FRAC_BITS(FRAC_BITS)
  ) u_date (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .year         (year),
    .month        (month),
    .day          (day),
    .hour         (hour),
    .minute       (minute),
    .second_fixed (second_fixed),
    .dn_valid     (date_valid),
    .dn_stall     (date_stall),
    .dn_data      (date_data)
  );

  c2gb_divide u_divide (
    .clk      (clk),
    .rst      (rst),
    .up_valid (date_valid),
    .up_stall (date_stall),
    .up_data  (date_data),
    .dn_valid (split_valid),
    .dn_stall (split_stall),
    .dn_data  (split_data)
  );

  c2gb_assemble #(
    .FRAC_BITS(FRAC_BITS)
  ) u_assemble (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (split_valid),
    .up_stall     (split_stall),
    .up_data      (split_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .gps_week     (gps_week),
    .gps_seconds  (gps_seconds),
    .bds_week     (bds_week),
    .bds_seconds  (bds_seconds),
    .before_epoch (before_epoch)
  );

endmodule

// File: dv/tb_calendar_to_gps_bds_week_second_top.sv
// testbench for the calendar to gps / beidou week and seconds converter
`timescale 1ns / 100ps

module tb_calendar_to_gps_bds_week_second_top;
  import c2gb_pkg::*;

  localparam int FRAC = 20;
  localparam int RANDOM_ITEMS = 750;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_ITEMS = 80;

  localparam longint DayEpoch = DAYS_TO_EPOCH;
  localparam longint DaySec = DAY_SECONDS;
  localparam longint WeekSec = SEC_PER_WEEK;
  localparam longint BdsWeeks = BDS_WEEK_OFFSET;
  localparam longint BdsSec = BDS_SEC_OFFSET;
  localparam int unsigned SecMax = 63963135;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [25:0] second_fixed;
  } stamp_t;

  typedef struct packed {
    logic [16:0] gps_week;
    logic [39:0] gps_seconds;
    logic [17:0] bds_week;
    logic [39:0] bds_seconds;
    logic        before_epoch;
  } week_time_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  stamp_t drive_stamp = '0;

  logic [11:0]        year;
  logic [3:0]         month;
  logic [4:0]         day;
  logic [4:0]         hour;
  logic [5:0]         minute;
  logic [25:0]        second_fixed;
  logic [16:0]        gps_week;
  logic [39:0]        gps_seconds;
  logic signed [17:0] bds_week;
  logic [39:0]        bds_seconds;
  logic               before_epoch;

  stamp_t     stamp_queue[$];
  week_time_t pending_weeks[$];
  int         errors = 0;
  int         cycles = 0;
  int         send_gap = 0;
  int         stall_left = 0;

  assign year         = drive_stamp.year;
  assign month        = drive_stamp.month;
  assign day          = drive_stamp.day;
  assign hour         = drive_stamp.hour;
  assign minute       = drive_stamp.minute;
  assign second_fixed = drive_stamp.second_fixed;

  calendar_to_gps_bds_week_second_top #(
    .FRAC_BITS(FRAC)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .year        (year),
    .month       (month),
    .day         (day),
    .hour        (hour),
    .minute      (minute),
    .second_fixed(second_fixed),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .gps_week    (gps_week),
    .gps_seconds (gps_seconds),
    .bds_week    (bds_week),
    .bds_seconds (bds_seconds),
    .before_epoch(before_epoch)
  );

  always #2 clk = ~clk;

  // exact week / seconds-of-week for one timestamp
  function automatic week_time_t gps_bds_time(stamp_t s);
    longint one, yr, mo, dy, hr, mn, sx, quarter, days, total;
    longint week_len, gweek, gsec, bweek, bsec;
    week_time_t r;
    one = longint'(1) << FRAC;
    yr = s.year;
    mo = s.month;
    dy = s.day;
    hr = s.hour;
    mn = s.minute;
    sx = s.second_fixed;
    r = '0;
    // january, february and month zero count as months of the previous year
    if (mo <= 2) begin
      yr = yr - 1;
      mo = mo + 12;
    end
    quarter = 1461 * yr;
    quarter = quarter >>> 2;
    days = quarter + (306001 * (mo + 1)) / 10000 + dy - DayEpoch;
    total = days * DaySec * one + (hr * 3600 + mn * 60) * one + sx;
    if (total < 0) begin
      r.before_epoch = 1'b1;
      return r;
    end
    week_len = WeekSec * one;
    gweek = total / week_len;
    gsec = total % week_len;
    bweek = gweek - BdsWeeks;
    bsec = gsec - BdsSec * one;
    if (bsec < 0) begin
      bsec = bsec + week_len;
      bweek = bweek - 1;
    end
    r.gps_week = gweek[16:0];
    r.gps_seconds = gsec[39:0];
    r.bds_week = bweek[17:0];
    r.bds_seconds = bsec[39:0];
    return r;
  endfunction

  function automatic stamp_t stamp(int y, int mo, int d, int h, int mi, int unsigned sx);
    stamp_t s;
    s.year = 12'(y);
    s.month = 4'(mo);
    s.day = 5'(d);
    s.hour = 5'(h);
    s.minute = 6'(mi);
    s.second_fixed = 26'(sx);
    return s;
  endfunction

  function automatic stamp_t random_stamp();
    stamp_t s;
    int kind;
    kind = $urandom_range(0, 9);
    s = stamp($urandom_range(1980, 4095), $urandom_range(1, 12), $urandom_range(1, 31),
              $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, SecMax));
    case (kind)
      0: s = 58'({$urandom, $urandom});
      1: s.second_fixed = 26'($urandom);
      2: begin
        // around the gps epoch
        s.year = 12'($urandom_range(1979, 1980));
        s.month = $urandom_range(0, 1) ? 4'd1 : 4'd12;
        s.day = 5'($urandom_range(1, 14));
      end
      3: begin
        // around the beidou epoch, where the seconds borrow a week
        s.year = 12'($urandom_range(2005, 2006));
        s.month = $urandom_range(0, 1) ? 4'd1 : 4'd12;
        s.day = $urandom_range(0, 1) ? 5'd1 : 5'd31;
        s.hour = $urandom_range(0, 1) ? 5'd0 : 5'd23;
        s.minute = $urandom_range(0, 1) ? 6'd0 : 6'd59;
      end
      4: begin
        s.day = 5'($urandom);
        s.hour = 5'($urandom);
        s.minute = 6'($urandom);
        s.month = 4'($urandom);
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic bit tail_phase();
    return stamp_queue.size() < TAIL_ITEMS;
  endfunction

  // alternate stretches with and without idling
  function automatic bit idle_allowed();
    return !tail_phase() && ((stamp_queue.size() / 64) % 3 != 1);
  endfunction

  task automatic check_field(string fld, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, fld, want, got);
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_weeks.push_back(gps_bds_time(drive_stamp));
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (stamp_queue.size() > 0) begin
          drive_stamp <= stamp_queue.pop_front();
          in_valid <= 1'b1;
          if (idle_allowed() && $urandom_range(0, 12) == 0) begin
            send_gap = $urandom_range(1, 19);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and stall generator
  always @(posedge clk) begin
    week_time_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_weeks.size() == 0) begin
          errors++;
          $display("%0t: result transfer with nothing expected, gps_week %0h", $time,
                   gps_week);
        end else begin
          want = pending_weeks.pop_front();
          check_field("gps_week", want.gps_week, gps_week);
          check_field("gps_seconds", want.gps_seconds, gps_seconds);
          check_field("bds_week", want.bds_week, $unsigned(bds_week));
          check_field("bds_seconds", want.bds_seconds, bds_seconds);
          check_field("before_epoch", want.before_epoch, before_epoch);
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (idle_allowed() && $urandom_range(0, 15) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(1, 19) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[calendar_to_gps_bds_week_second_top] ERROR");
      $finish;
    end
  end

  initial begin
    // epoch, one lsb before it, and year zero
    stamp_queue.push_back(stamp(1980, 1, 6, 0, 0, 0));
    stamp_queue.push_back(stamp(1980, 1, 5, 23, 59, (60 << FRAC) - 1));
    stamp_queue.push_back(stamp(0, 1, 1, 0, 0, 0));
    stamp_queue.push_back(stamp(0, 2, 28, 23, 59, SecMax));
    stamp_queue.push_back(stamp(0, 0, 0, 0, 0, 0));
    // gps week boundary
    stamp_queue.push_back(stamp(1980, 1, 12, 23, 59, (60 << FRAC) - 1));
    stamp_queue.push_back(stamp(1980, 1, 13, 0, 0, 0));
    // beidou seconds borrow a week right after the gps epoch
    stamp_queue.push_back(stamp(1980, 1, 6, 0, 0, 13 << FRAC));
    // beidou epoch and one lsb before it
    stamp_queue.push_back(stamp(2006, 1, 1, 0, 0, 14 << FRAC));
    stamp_queue.push_back(stamp(2006, 1, 1, 0, 0, (14 << FRAC) - 1));
    // month zero and months past december
    stamp_queue.push_back(stamp(2000, 0, 15, 12, 0, 0));
    stamp_queue.push_back(stamp(2000, 13, 15, 12, 0, 0));
    stamp_queue.push_back(stamp(2000, 14, 15, 12, 0, 0));
    stamp_queue.push_back(stamp(2000, 15, 15, 12, 0, 0));
    stamp_queue.push_back(stamp(2000, 1, 31, 6, 30, 1 << FRAC));
    stamp_queue.push_back(stamp(2000, 2, 29, 6, 30, 1 << FRAC));
    // day zero and fields beyond their ranges carrying forward
    stamp_queue.push_back(stamp(2000, 3, 0, 0, 0, 0));
    stamp_queue.push_back(stamp(2010, 6, 31, 31, 63, 26'h3ffffff));
    stamp_queue.push_back(stamp(2024, 2, 29, 12, 30, (30 << FRAC) + (1 << (FRAC - 1))));
    // leap second and the top of the year range
    stamp_queue.push_back(stamp(2016, 12, 31, 23, 59, SecMax));
    stamp_queue.push_back(stamp(4095, 12, 31, 23, 59, SecMax));
    stamp_queue.push_back(stamp(4095, 15, 31, 31, 63, 26'h3ffffff));
    stamp_queue.push_back(stamp(1979, 12, 31, 23, 59, 0));
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      stamp_queue.push_back(random_stamp());
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (stamp_queue.size() > 0 || in_valid || pending_weeks.size() > 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("[calendar_to_gps_bds_week_second_top] OK");
    end else begin
      $display("[calendar_to_gps_bds_week_second_top] ERROR");
    end
    $finish;
  end

endmodule
